// ----- hw/rtl/jos_pkg.sv -----
`default_nettype none

package jos_pkg;

  // Fixed widths of the request and result fields.
  localparam int unsigned OpW     = 4;
  localparam int unsigned FieldW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 3;

  typedef enum logic [OpW-1:0] {
    OP_PUSH    = 4'd0,
    OP_POP     = 4'd1,
    OP_POP2    = 4'd2,
    OP_DUP     = 4'd3,
    OP_DUP_X1  = 4'd4,
    OP_DUP_X2  = 4'd5,
    OP_DUP2    = 4'd6,
    OP_DUP2_X1 = 4'd7,
    OP_DUP2_X2 = 4'd8,
    OP_SWAP    = 4'd9
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  // Source of one slot written back: a slot read from the top, or the pushed value.
  typedef enum logic [2:0] {
    SRC_V1   = 3'd0,
    SRC_V2   = 3'd1,
    SRC_V3   = 3'd2,
    SRC_V4   = 3'd3,
    SRC_PUSH = 3'd4
  } src_e;

  // Controller to datapath.
  typedef struct packed {
    logic accept;     // take the request into the working registers
    logic rd_deep;    // read the third and fourth slots instead of the top two
    logic capt_lo;    // capture the top two slots
    logic capt_hi;    // capture the third and fourth slots
    logic wr_en;      // write one replacement slot
    logic sp_commit;  // move the stack pointer to its new value
    logic out_load;   // load the result register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic go;         // request is a known op that neither underflows nor overflows
    logic n_zero;     // op writes no slot back
    logic wr_last;    // current write is the last one
    logic out_busy;   // result register holds a result not yet taken
  } stat_t;

  // Slots the op consumes from the top.
  function automatic logic [CountW-1:0] op_need(op_e op);
    logic [CountW-1:0] r;
    unique case (op) inside
      OP_PUSH:                        r = 3'd0;
      OP_POP, OP_DUP:                 r = 3'd1;
      OP_POP2, OP_DUP_X1, OP_DUP2,
      OP_SWAP:                        r = 3'd2;
      OP_DUP_X2, OP_DUP2_X1:          r = 3'd3;
      OP_DUP2_X2:                     r = 3'd4;
      default:                        r = 3'd0;
    endcase
    return r;
  endfunction

  // Slots the op puts back in place of those it consumed.
  function automatic logic [CountW-1:0] op_count(op_e op);
    logic [CountW-1:0] r;
    unique case (op) inside
      OP_PUSH:                        r = 3'd1;
      OP_POP, OP_POP2:                r = 3'd0;
      OP_DUP, OP_SWAP:                r = 3'd2;
      OP_DUP_X1:                      r = 3'd3;
      OP_DUP_X2, OP_DUP2:             r = 3'd4;
      OP_DUP2_X1:                     r = 3'd5;
      OP_DUP2_X2:                     r = 3'd6;
      default:                        r = 3'd0;
    endcase
    return r;
  endfunction

  // Replacement slot idx, counted from the bottom of the rewritten region.
  function automatic src_e op_src(op_e op, logic [CountW-1:0] idx);
    src_e r;
    r = SRC_V1;
    unique case (op)
      OP_PUSH: r = SRC_PUSH;
      OP_DUP_X1: begin
        if (idx == 3'd1) r = SRC_V2;
      end
      OP_DUP_X2: begin
        if (idx == 3'd1) r = SRC_V3;
        else if (idx == 3'd2) r = SRC_V2;
      end
      OP_DUP2: begin
        if (idx == 3'd0 || idx == 3'd2) r = SRC_V2;
      end
      OP_DUP2_X1: begin
        if (idx == 3'd0 || idx == 3'd3) r = SRC_V2;
        else if (idx == 3'd2) r = SRC_V3;
      end
      OP_DUP2_X2: begin
        if (idx == 3'd0 || idx == 3'd4) r = SRC_V2;
        else if (idx == 3'd2) r = SRC_V4;
        else if (idx == 3'd3) r = SRC_V3;
      end
      OP_SWAP: begin
        if (idx == 3'd1) r = SRC_V2;
      end
      default: r = SRC_V1;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/jos_ram.sv -----
`default_nettype none

module jos_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/jos_ctrl.sv -----
`default_nettype none

module jos_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire jos_pkg::stat_t stat_i,
  output jos_pkg::cmd_t       cmd_o
);

  import jos_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_RDA    = 7'b0000010,
    S_RDB    = 7'b0000100,
    S_CAPT   = 7'b0001000,
    S_WRITE  = 7'b0010000,
    S_TOPRD  = 7'b0100000,
    S_TOPCAP = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = stat_i.go ? S_RDA : S_TOPRD;
        end
      end
      S_RDA: begin
        state_d = S_RDB;
      end
      S_RDB: begin
        cmd_o.capt_lo = 1'b1;
        cmd_o.rd_deep = 1'b1;
        state_d       = S_CAPT;
      end
      S_CAPT: begin
        cmd_o.capt_hi = 1'b1;
        if (stat_i.n_zero) begin
          cmd_o.sp_commit = 1'b1;
          state_d         = S_TOPRD;
        end else begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.wr_en = 1'b1;
        if (stat_i.wr_last) begin
          cmd_o.sp_commit = 1'b1;
          state_d         = S_TOPRD;
        end
      end
      S_TOPRD: begin
        state_d = S_TOPCAP;
      end
      S_TOPCAP: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/jos_dpath.sv -----
`default_nettype none

module jos_dpath #(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned SLOT_WIDTH  = 32,
  localparam int unsigned DepthW = $clog2(STACK_DEPTH + 1)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire jos_pkg::cmd_t                  cmd_i,
  output jos_pkg::stat_t                      stat_o,
  input  wire logic [jos_pkg::OpW-1:0]        op_i,
  input  wire logic [jos_pkg::FieldW-1:0]     push_value_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [jos_pkg::StatusW-1:0]    status_o,
  output logic      [DepthW-1:0]              depth_o,
  output logic      [jos_pkg::FieldW-1:0]     top_value_o,
  output logic      [jos_pkg::FieldW-1:0]     next_value_o
);

  import jos_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam logic [DepthW:0] DepthLimit = (DepthW + 1)'(STACK_DEPTH);

  op_e                   op_q;
  logic [SLOT_WIDTH-1:0] push_q;
  status_e               status_q, status_d;
  logic [DepthW-1:0]     sp_q, sp_d;
  logic [CountW-1:0]     cnt_q, cnt_d;
  logic [SLOT_WIDTH-1:0] v_q [4];
  logic                  out_valid_q;
  status_e               out_status_q;
  logic [DepthW-1:0]     out_depth_q;
  logic [FieldW-1:0]     out_top_q, out_next_q;

  // Request check
  op_e               op_in;
  logic              op_known, under, over;
  logic [DepthW:0]   grown;
  logic [CountW-1:0] need_in, count_in;

  always_comb begin
    op_in    = op_e'(op_i);
    op_known = (op_i <= OpW'(OP_SWAP));
    need_in  = op_need(op_in);
    count_in = op_count(op_in);
    under    = sp_q < DepthW'(need_in);
    grown    = {1'b0, sp_q} - (DepthW + 1)'(need_in) + (DepthW + 1)'(count_in);
    over     = grown > DepthLimit;
    if (!op_known) status_d = ST_OK;
    else if (under) status_d = ST_UNDERFLOW;
    else if (over) status_d = ST_OVERFLOW;
    else status_d = ST_OK;
  end

  // Addresses
  logic [DepthW-1:0]     base, wr_slot, rd_a_slot, rd_b_slot;
  logic [CountW-1:0]     count_cur;
  logic [SLOT_WIDTH-1:0] wr_data, rd_a, rd_b;
  src_e                  src;

  always_comb begin
    count_cur = op_count(op_q);
    base      = sp_q - DepthW'(op_need(op_q));
    wr_slot   = base + DepthW'(cnt_q);
    rd_a_slot = cmd_i.rd_deep ? sp_q - DepthW'(3) : sp_q - DepthW'(1);
    rd_b_slot = rd_a_slot - DepthW'(1);
    sp_d      = base + DepthW'(count_cur);
    cnt_d     = cmd_i.accept ? '0 : (cmd_i.wr_en ? cnt_q + CountW'(1) : cnt_q);
    src       = op_src(op_q, cnt_q);
    case (src)
      SRC_V1:   wr_data = v_q[0];
      SRC_V2:   wr_data = v_q[1];
      SRC_V3:   wr_data = v_q[2];
      SRC_V4:   wr_data = v_q[3];
      SRC_PUSH: wr_data = push_q;
      default:  wr_data = v_q[0];
    endcase
  end

  jos_ram #(
    .WIDTH (SLOT_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (cmd_i.wr_en),
    .waddr_i   (wr_slot[AW-1:0]),
    .wdata_i   (wr_data),
    .raddr_a_i (rd_a_slot[AW-1:0]),
    .raddr_b_i (rd_b_slot[AW-1:0]),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  always_comb begin
    stat_o.go       = op_known && !under && !over;
    stat_o.n_zero   = (count_cur == '0);
    stat_o.wr_last  = (cnt_q == count_cur - CountW'(1));
    stat_o.out_busy = out_valid_q && out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.sp_commit) begin
        sp_q <= sp_d;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q     <= op_in;
      push_q   <= SLOT_WIDTH'(push_value_i);
      status_q <= status_d;
    end
    if (cmd_i.capt_lo) begin
      v_q[0] <= rd_a;
      v_q[1] <= rd_b;
    end
    if (cmd_i.capt_hi) begin
      v_q[2] <= rd_a;
      v_q[3] <= rd_b;
    end
    if (cmd_i.out_load) begin
      out_status_q <= status_q;
      out_depth_q  <= sp_q;
      out_top_q    <= (sp_q >= DepthW'(1)) ? FieldW'(rd_a) : '0;
      out_next_q   <= (sp_q >= DepthW'(2)) ? FieldW'(rd_b) : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign depth_o      = out_depth_q;
  assign top_value_o  = out_top_q;
  assign next_value_o = out_next_q;

`ifndef SYNTHESIS
  a_sp_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= DepthW'(STACK_DEPTH))
    else $error("stack pointer past stack depth");

  a_sp_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.sp_commit |=> $stable(sp_q))
    else $error("stack pointer moved without a commit");

  a_wr_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |-> (wr_slot < sp_d) && (wr_slot >= base))
    else $error("slot write outside the rewritten region");

  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten while held");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/jvm_operand_stack_shuffle.sv -----
`default_nettype none

// Channel   Direction  Handshake                  Payload
// request   in         in_valid_i / in_stall_o    op_i, push_value_i
// result    out        out_valid_o / out_stall_i  status_o, depth_o, top_value_o, next_value_o
//
// One request at a time; n is the slots an op writes back (0 for pop, up to 6 for dup2_x2).
// A known op that passes the depth checks reads the top slots, writes its n replacement slots
// one at a time through the single write port of the slot RAM, then reads back the new top
// two and loads the result register. Underflow, overflow and unused ops only do the read-back.
// Reset empties the stack; slot contents are not cleared and need no sweep.
// A held result stalls only the final load, and with it the next request.

module jvm_operand_stack_shuffle #(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned SLOT_WIDTH  = 32,
  localparam int unsigned DepthW = $clog2(STACK_DEPTH + 1)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // request channel
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [jos_pkg::OpW-1:0]        op_i,
  input  wire logic [jos_pkg::FieldW-1:0]     push_value_i,
  // result channel
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [jos_pkg::StatusW-1:0]    status_o,
  output logic      [DepthW-1:0]              depth_o,
  output logic      [jos_pkg::FieldW-1:0]     top_value_o,
  output logic      [jos_pkg::FieldW-1:0]     next_value_o
);

  import jos_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequence: read top slots, rewrite the region, read back the new top two.
  jos_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Hold the stack pointer, the slot RAM, the captured slots and the result register.
  jos_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .SLOT_WIDTH  (SLOT_WIDTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .op_i         (op_i),
    .push_value_i (push_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .depth_o      (depth_o),
    .top_value_o  (top_value_o),
    .next_value_o (next_value_o)
  );

endmodule

`default_nettype wire

// ----- tb/jos_stack_checker.sv -----
`timescale 1ns / 1ps

module jos_stack_checker #(
  parameter int unsigned StackDepth = 64,
  localparam int unsigned DepthW = $clog2(StackDepth + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          req_valid_i,
  input  wire logic                          req_stall_i,
  input  wire logic [jos_pkg::OpW-1:0]       req_op_i,
  input  wire logic [jos_pkg::FieldW-1:0]    req_value_i,
  input  wire logic                          rsp_valid_i,
  input  wire logic                          rsp_stall_i,
  input  wire logic [jos_pkg::StatusW-1:0]   rsp_status_i,
  input  wire logic [DepthW-1:0]             rsp_depth_i,
  input  wire logic [jos_pkg::FieldW-1:0]    rsp_top_i,
  input  wire logic [jos_pkg::FieldW-1:0]    rsp_second_i,
  output int                                 mismatches_o,
  output int                                 outstanding_o,
  output int                                 results_o,
  output int                                 underflows_o,
  output int                                 overflows_o,
  output int                                 peak_depth_o
);

  import jos_pkg::*;

  localparam int unsigned MaxPrinted = 30;

  typedef struct {
    status_e           status;
    logic [DepthW-1:0] depth;
    logic [FieldW-1:0] top_slot;
    logic [FieldW-1:0] second_slot;
  } stack_report_t;

  logic [FieldW-1:0] slots [StackDepth];
  int unsigned       stack_ptr;
  stack_report_t     expected_reports [$];
  stack_report_t     want;

  // Apply one bytecode to the shadow stack and return the report it yields.
  function automatic stack_report_t execute_bytecode(input logic [OpW-1:0] code,
                                                     input logic [FieldW-1:0] value);
    stack_report_t     rpt;
    logic [FieldW-1:0] v1, v2, v3, v4;
    logic [FieldW-1:0] fill [6];
    int unsigned       need, refill, base;
    rpt.status = ST_OK;
    need = 0;
    refill = 0;
    v1 = '0;
    v2 = '0;
    v3 = '0;
    v4 = '0;
    if (code <= OP_SWAP) begin
      case (op_e'(code))
        OP_PUSH: begin
          need = 0; refill = 1;
        end
        OP_POP: begin
          need = 1; refill = 0;
        end
        OP_POP2: begin
          need = 2; refill = 0;
        end
        OP_DUP: begin
          need = 1; refill = 2;
        end
        OP_DUP_X1: begin
          need = 2; refill = 3;
        end
        OP_DUP_X2: begin
          need = 3; refill = 4;
        end
        OP_DUP2: begin
          need = 2; refill = 4;
        end
        OP_DUP2_X1: begin
          need = 3; refill = 5;
        end
        OP_DUP2_X2: begin
          need = 4; refill = 6;
        end
        default: begin
          need = 2; refill = 2;
        end
      endcase
      if (stack_ptr < need) begin
        rpt.status = ST_UNDERFLOW;
      end else if (stack_ptr - need + refill > StackDepth) begin
        rpt.status = ST_OVERFLOW;
      end else begin
        if (need >= 1) v1 = slots[stack_ptr-1];
        if (need >= 2) v2 = slots[stack_ptr-2];
        if (need >= 3) v3 = slots[stack_ptr-3];
        if (need >= 4) v4 = slots[stack_ptr-4];
        // replacement slots, bottom to top
        case (op_e'(code))
          OP_PUSH: fill[0] = value;
          OP_DUP: begin
            fill[0] = v1; fill[1] = v1;
          end
          OP_DUP_X1: begin
            fill[0] = v1; fill[1] = v2; fill[2] = v1;
          end
          OP_DUP_X2: begin
            fill[0] = v1; fill[1] = v3; fill[2] = v2; fill[3] = v1;
          end
          OP_DUP2: begin
            fill[0] = v2; fill[1] = v1; fill[2] = v2; fill[3] = v1;
          end
          OP_DUP2_X1: begin
            fill[0] = v2; fill[1] = v1; fill[2] = v3; fill[3] = v2; fill[4] = v1;
          end
          OP_DUP2_X2: begin
            fill[0] = v2; fill[1] = v1; fill[2] = v4;
            fill[3] = v3; fill[4] = v2; fill[5] = v1;
          end
          OP_SWAP: begin
            fill[0] = v1; fill[1] = v2;
          end
          default: ;
        endcase
        base = stack_ptr - need;
        for (int i = 0; i < refill; i++) slots[base+i] = fill[i];
        stack_ptr = base + refill;
      end
    end
    rpt.depth = DepthW'(stack_ptr);
    rpt.top_slot = (stack_ptr >= 1) ? slots[stack_ptr-1] : '0;
    rpt.second_slot = (stack_ptr >= 2) ? slots[stack_ptr-2] : '0;
    return rpt;
  endfunction

  task automatic report_mismatch(input string what, input logic [FieldW-1:0] got,
                                 input logic [FieldW-1:0] exp_val);
    mismatches_o++;
    if (mismatches_o <= MaxPrinted)
      $display("[%0t] result %0d: %s is 0x%0h, want 0x%0h", $time, results_o, what, got,
               exp_val);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_ptr = 0;
      foreach (slots[i]) slots[i] = '0;
      expected_reports.delete();
      outstanding_o <= 0;
      mismatches_o = 0;
      results_o = 0;
      underflows_o = 0;
      overflows_o = 0;
      peak_depth_o = 0;
    end else begin
      if (req_valid_i && !req_stall_i) begin
        want = execute_bytecode(req_op_i, req_value_i);
        if (want.status == ST_UNDERFLOW) underflows_o++;
        if (want.status == ST_OVERFLOW) overflows_o++;
        if (int'(want.depth) > peak_depth_o) peak_depth_o = int'(want.depth);
        expected_reports.push_back(want);
      end
      if (rsp_valid_i && !rsp_stall_i) begin
        results_o++;
        if (expected_reports.size() == 0) begin
          report_mismatch("result with no request waiting, status",
                          FieldW'(rsp_status_i), '0);
        end else begin
          want = expected_reports.pop_front();
          if (rsp_status_i !== want.status)
            report_mismatch("status", FieldW'(rsp_status_i), FieldW'(want.status));
          if (rsp_depth_i !== want.depth)
            report_mismatch("depth", FieldW'(rsp_depth_i), FieldW'(want.depth));
          if (rsp_top_i !== want.top_slot)
            report_mismatch("top_value", rsp_top_i, want.top_slot);
          if (rsp_second_i !== want.second_slot)
            report_mismatch("next_value", rsp_second_i, want.second_slot);
        end
      end
      outstanding_o <= expected_reports.size();
    end
  end

endmodule

// ----- tb/tb_jvm_operand_stack_shuffle.sv -----
`timescale 1ns / 1ps

module tb_jvm_operand_stack_shuffle;
  import jos_pkg::*;

  localparam int unsigned StackDepth     = 64;
  localparam int unsigned SlotWidth      = 32;
  localparam int unsigned DepthW         = $clog2(StackDepth + 1);
  localparam int unsigned RandomRequests = 1100;
  localparam int unsigned BurstLen       = 80;     // requests per op mix
  localparam int unsigned HoldOffCycles  = 300;    // long result hold-off
  localparam int unsigned DrainCycles    = 24;     // idle wait for stray results after the drain
  localparam int unsigned CycleLimit     = 500000;

  // Opcodes past swap are unused; the block must treat them as no-ops.
  localparam logic [OpW-1:0] UnusedOpLo = OpW'(int'(OP_SWAP) + 1);
  localparam logic [OpW-1:0] UnusedOpHi = '1;

  // Op mixes: fill drives the stack into overflow, drain into underflow.
  typedef enum {MIX_FILL, MIX_DRAIN, MIX_ANY} op_mix_e;

  logic                clk;
  logic                rst_n;
  logic                req_valid;
  logic                req_stall;
  logic [OpW-1:0]      req_op;
  logic [FieldW-1:0]   req_value;
  logic                rsp_valid;
  logic                rsp_stall;
  logic [StatusW-1:0]  rsp_status;
  logic [DepthW-1:0]   rsp_depth;
  logic [FieldW-1:0]   rsp_top;
  logic [FieldW-1:0]   rsp_second;

  int mismatches;
  int outstanding;
  int results;
  int underflows;
  int overflows;
  int peak_depth;

  int send_idle_pct = 32;
  int recv_idle_pct = 70;
  int requests_sent = 0;
  int cycle_count   = 0;
  bit hold_off_armed = 1'b0;
  bit hold_off_done  = 1'b0;

  jvm_operand_stack_shuffle #(
    .STACK_DEPTH(StackDepth),
    .SLOT_WIDTH (SlotWidth)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_stall_o  (req_stall),
    .op_i        (req_op),
    .push_value_i(req_value),
    .out_valid_o (rsp_valid),
    .out_stall_i (rsp_stall),
    .status_o    (rsp_status),
    .depth_o     (rsp_depth),
    .top_value_o (rsp_top),
    .next_value_o(rsp_second)
  );

  // The checker shadows the stack, predicts each result and counts mismatches.
  jos_stack_checker #(
    .StackDepth(StackDepth)
  ) u_stack_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_valid_i  (req_valid),
    .req_stall_i  (req_stall),
    .req_op_i     (req_op),
    .req_value_i  (req_value),
    .rsp_valid_i  (rsp_valid),
    .rsp_stall_i  (rsp_stall),
    .rsp_status_i (rsp_status),
    .rsp_depth_i  (rsp_depth),
    .rsp_top_i    (rsp_top),
    .rsp_second_i (rsp_second),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding),
    .results_o    (results),
    .underflows_o (underflows),
    .overflows_o  (overflows),
    .peak_depth_o (peak_depth)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offer one request, after a random gap, and hold it until it is taken.
  // Valid stays high after acceptance so back-to-back requests need no extra edge.
  task automatic send_request(input logic [OpW-1:0] code, input logic [FieldW-1:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_valid <= 1'b1;
    req_op    <= code;
    req_value <= value;
    do @(posedge clk); while (req_stall);
    requests_sent++;
  endtask

  function automatic logic [OpW-1:0] pick_bytecode(input op_mix_e mix);
    int unsigned    roll;
    logic [OpW-1:0] code;
    roll = $urandom_range(99);
    code = OpW'($urandom_range(OP_SWAP, OP_PUSH));
    case (mix)
      MIX_FILL: begin
        // pushes plus the dup family grow the stack by about one slot per request
        if (roll < 45) code = OP_PUSH;
        else if (roll < 80) code = OpW'($urandom_range(OP_DUP2_X2, OP_DUP));
      end
      MIX_DRAIN: begin
        if (roll < 35) code = OP_POP;
        else if (roll < 60) code = OP_POP2;
        else if (roll < 70) code = OP_PUSH;
      end
      default: begin
        if (roll < 6) code = OpW'($urandom_range(UnusedOpHi, UnusedOpLo));
      end
    endcase
    return code;
  endfunction

  function automatic logic [FieldW-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return $urandom;
  endfunction

  // Receiver: stall at random per phase; once, hold off long enough that the
  // block parks a result, takes one more request and then stalls its input.
  initial begin
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_armed && !hold_off_done) begin
        hold_off_done = 1'b1;
        rsp_stall <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk);
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: end the run if the block hangs.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d requests sent, %0d results pending",
             cycle_count, requests_sent, outstanding);
    $display("tb_jvm_operand_stack_shuffle failed");
    $finish;
  end

  initial begin
    op_mix_e mix;
    rst_n     <= 1'b0;
    req_valid <= 1'b0;
    req_op    <= OP_PUSH;
    req_value <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Empty stack: every consumer must underflow and leave the stack empty.
    send_request(OP_POP, '0);
    send_request(OP_SWAP, '1);
    send_request(OP_DUP2_X2, $urandom);
    // Unused opcodes report ok and change nothing, also on an empty stack.
    send_request(UnusedOpLo, '1);
    send_request(UnusedOpHi, '0);
    // Load four distinct slots with extreme values.
    send_request(OP_PUSH, '1);
    send_request(OP_PUSH, '0);
    send_request(OP_PUSH, 32'h8000_0001);
    send_request(OP_PUSH, 32'h7FFF_FFFE);
    // Walk every shuffle once with four or more slots present.
    send_request(OP_DUP2_X2, '0);
    send_request(OP_DUP2_X1, '0);
    send_request(OP_DUP2, '0);
    send_request(OP_DUP_X2, '0);
    send_request(OP_DUP_X1, '0);
    send_request(OP_DUP, '0);
    send_request(OP_SWAP, '0);
    send_request(OP_POP, '1);
    send_request(OP_POP2, '1);

    // Random part in three idle phases; switch op mix every burst so the
    // stack swings between full and empty.
    mix = MIX_ANY;
    for (int i = 0; i < RandomRequests; i++) begin
      if (i == RandomRequests / 3) begin
        send_idle_pct = 70;
        recv_idle_pct = 32;
      end
      if (i == 2 * RandomRequests / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_armed = 1'b1;
      end
      if (i % BurstLen == 0) begin
        case ($urandom_range(99) / 35)
          0: mix = MIX_FILL;
          1: mix = MIX_DRAIN;
          default: mix = MIX_ANY;
        endcase
      end
      send_request(pick_bytecode(mix), pick_value());
    end
    req_valid <= 1'b0;

    // Drain: wait for every predicted result, then watch for strays.
    do @(posedge clk); while (outstanding != 0);
    repeat (DrainCycles) @(posedge clk);

    $display("%0d requests sent, %0d results checked, %0d mismatches",
             requests_sent, results, mismatches);
    $display("stack reached depth %0d; %0d underflows and %0d overflows exercised",
             peak_depth, underflows, overflows);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_jvm_operand_stack_shuffle passed");
    end else begin
      $display("tb_jvm_operand_stack_shuffle failed");
    end
    $finish;
  end

endmodule
